// ----- hw/rtl/color_histogram_pixel_classifier_defines.svh -----
// ----------------------------------------------------------------------------
// Colour histogram classifier assertion macros
// Shared concurrent checks, clocked on the rising edge, off during reset.
// ----------------------------------------------------------------------------
`ifndef COLOR_HISTOGRAM_PIXEL_CLASSIFIER_DEFINES_SVH
`define COLOR_HISTOGRAM_PIXEL_CLASSIFIER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CHPC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CHPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/chpc_pkg.sv -----
// ----------------------------------------------------------------------------
// Colour histogram classifier package
// Sizes, codes and controller/datapath command and status types.
// ----------------------------------------------------------------------------
package chpc_pkg;

	localparam int BINS_PER_CHANNEL = 12;
	localparam int COUNT_WIDTH      = 20;

	localparam int HIST_DEPTH  = BINS_PER_CHANNEL * BINS_PER_CHANNEL * BINS_PER_CHANNEL;
	localparam int ADDR_W      = $clog2(HIST_DEPTH);
	localparam int BIN_W       = $clog2(BINS_PER_CHANNEL);
	localparam int BIN_INDEX_W = 11;
	localparam int HITS_W      = 20;
	localparam int CHAN_W      = 8;
	localparam int CMD_W       = 2;

	// probability in Q0.16, one extra bit to hold exactly 1.0
	localparam int PROB_W    = 17;
	localparam int DIV_STEPS = PROB_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);
	localparam int RATIO_W   = 16;
	localparam int PROD_W    = PROB_W + RATIO_W;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;

	localparam logic [7:0]  BIN_DIVISOR_RST = 8'd21;
	localparam logic [15:0] PROB_FLOOR_RST  = 16'd66;
	localparam logic [15:0] RATIO_RST       = 16'd444;

	typedef enum logic [CMD_W-1:0] {
		CMD_TRAIN_OBJ = 2'd0,
		CMD_TRAIN_BG  = 2'd1,
		CMD_CLASSIFY  = 2'd2
	} pix_cmd_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_BIN_DIVISOR = 2'd0,
		CFG_PROB_FLOOR  = 2'd1,
		CFG_RATIO       = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic clear_wr;   // zero one entry of both histograms, advance sweep
		logic capture;    // latch the pixel's bin index
		logic lookup;     // read both histograms at the latched bin
		logic train_obj;  // write back incremented object bin and total
		logic train_bg;   // write back incremented background bin and total
		logic div_load;   // start both dividers from the read counts
		logic div_step;   // one quotient bit in each divider
		logic div_first;  // first quotient bit: no remainder shift
		logic mul;        // floor probabilities, form the cross product
		logic out_load;   // fill the output register
		logic judge;      // the loaded result is a classification
	} chpc_ctl_t;

	typedef struct packed {
		logic clear_last; // sweep is at the last entry
		logic out_busy;   // output register holds a beat not yet taken
	} chpc_sts_t;

endpackage

// ----- hw/rtl/chpc_in_if.sv -----
// ----------------------------------------------------------------------------
// Pixel input channel
// Valid/ready channel carrying one command and one BGR pixel per beat.
// ----------------------------------------------------------------------------
interface chpc_in_if import chpc_pkg::*;;
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  cmd;
	logic [CHAN_W-1:0] blue;
	logic [CHAN_W-1:0] green;
	logic [CHAN_W-1:0] red;

	modport source (output valid, cmd, blue, green, red, input ready);
	modport sink   (input valid, cmd, blue, green, red, output ready);
endinterface

// ----- hw/rtl/chpc_out_if.sv -----
// ----------------------------------------------------------------------------
// Classification result channel
// Valid/ready channel carrying one result per beat.
// ----------------------------------------------------------------------------
interface chpc_out_if import chpc_pkg::*;;
	logic                   valid;
	logic                   ready;
	logic                   is_object;
	logic [BIN_INDEX_W-1:0] bin_index;
	logic [HITS_W-1:0]      hit_count;

	modport source (output valid, is_object, bin_index, hit_count, input ready);
	modport sink   (input valid, is_object, bin_index, hit_count, output ready);
endinterface

// ----- hw/rtl/chpc_ctrl.sv -----
// ----------------------------------------------------------------------------
// Colour histogram classifier controller
// One-hot sequencer: clear sweep, lookup, train or divide, compare, emit.
// ----------------------------------------------------------------------------
module chpc_ctrl import chpc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [CMD_W-1:0] in_cmd,
	input  chpc_sts_t        sts,
	output chpc_ctl_t        ctl
);

	typedef enum logic [6:0] {
		S_CLEAR = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_LOOK  = 7'b0000100,
		S_READ  = 7'b0001000,
		S_DIV   = 7'b0010000,
		S_MUL   = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	state_t               state_q, state_d;
	logic [CMD_W-1:0]     cmd_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 accept;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		case (state_q)
			S_CLEAR: begin
				ctl.clear_wr = 1'b1;
				if (sts.clear_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (accept) begin
					ctl.capture = 1'b1;
					state_d     = S_LOOK;
				end
			end
			S_LOOK: begin
				ctl.lookup = 1'b1;
				state_d    = S_READ;
			end
			S_READ: begin
				ctl.train_obj = (cmd_q == CMD_TRAIN_OBJ);
				ctl.train_bg  = (cmd_q == CMD_TRAIN_BG);
				if (cmd_q == CMD_CLASSIFY) begin
					ctl.div_load = 1'b1;
					state_d      = S_DIV;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DIV: begin
				ctl.div_step  = 1'b1;
				ctl.div_first = (cnt_q == '0);
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) state_d = S_MUL;
			end
			S_MUL: begin
				ctl.mul = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!sts.out_busy) begin
					ctl.out_load = 1'b1;
					ctl.judge    = (cmd_q == CMD_CLASSIFY);
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			cmd_q   <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (accept) cmd_q <= in_cmd;
			if (ctl.div_load) cnt_q <= '0;
			else if (ctl.div_step) cnt_q <= cnt_q + 1'b1;
		end
	end

endmodule

// ----- hw/rtl/chpc_datapath.sv -----
// ----------------------------------------------------------------------------
// Colour histogram classifier datapath
// Bin quantiser, histogram memories, totals, dividers, ratio test, output.
// ----------------------------------------------------------------------------
module chpc_datapath import chpc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  chpc_ctl_t              ctl,
	output chpc_sts_t              sts,
	input  logic [CHAN_W-1:0]      blue,
	input  logic [CHAN_W-1:0]      green,
	input  logic [CHAN_W-1:0]      red,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   out_ready,
	output logic                   out_valid,
	output logic                   is_object,
	output logic [BIN_INDEX_W-1:0] bin_index,
	output logic [HITS_W-1:0]      hit_count
);

	localparam int THR_W = CHAN_W + BIN_W;

	// channel value to bin: count of bin edges k*d at or below the value
	function automatic logic [BIN_W-1:0] chan_bin(input logic [CHAN_W-1:0] v,
		input logic [CHAN_W-1:0] d);
		logic [THR_W-1:0] thr;
		logic [BIN_W-1:0] b;
		b = '0;
		for (int k = 1; k < BINS_PER_CHANNEL; k++) begin
			thr = THR_W'(k) * THR_W'(d);
			if (THR_W'(v) >= thr) b = BIN_W'(k);
		end
		return b;
	endfunction

	function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	logic [7:0]  bin_divisor_q;
	logic [15:0] prob_floor_q;
	logic [15:0] ratio_q;

	logic [COUNT_WIDTH-1:0] obj_hist [HIST_DEPTH];
	logic [COUNT_WIDTH-1:0] bg_hist  [HIST_DEPTH];
	logic [COUNT_WIDTH-1:0] obj_rd_q, bg_rd_q;
	logic [COUNT_WIDTH-1:0] obj_total_q, bg_total_q;

	logic [ADDR_W-1:0] clear_addr_q;
	logic [ADDR_W-1:0] idx_q;
	logic [ADDR_W-1:0] idx_d;
	logic [CHAN_W-1:0] div_eff;
	logic [BIN_W-1:0]  b_bin, g_bin, r_bin;

	logic [COUNT_WIDTH-1:0] obj_rem_q, bg_rem_q;
	logic [PROB_W-1:0]      obj_quo_q, bg_quo_q;
	logic [COUNT_WIDTH:0]   obj_trial, bg_trial;
	logic                   obj_bit, bg_bit;

	logic [PROB_W-1:0]  obj_p, bg_p, obj_pf, bg_pf;
	logic [PROB_W-1:0]  obj_pf_q;
	logic [PROD_W-1:0]  prod_q;
	logic               pass;
	logic               hit;
	logic [HITS_W-1:0]  hits_q, hits_inc;
	logic [ADDR_W+BIN_INDEX_W-1:0] idx_wide;

	// ---- quantise -----------------------------------------------------------
	assign div_eff = (bin_divisor_q == '0) ? CHAN_W'(1) : bin_divisor_q;
	assign b_bin   = chan_bin(blue,  div_eff);
	assign g_bin   = chan_bin(green, div_eff);
	assign r_bin   = chan_bin(red,   div_eff);
	assign idx_d   = ADDR_W'(b_bin) * ADDR_W'(BINS_PER_CHANNEL * BINS_PER_CHANNEL)
		+ ADDR_W'(g_bin) * ADDR_W'(BINS_PER_CHANNEL) + ADDR_W'(r_bin);

	// ---- configuration ------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_divisor_q <= BIN_DIVISOR_RST;
			prob_floor_q  <= PROB_FLOOR_RST;
			ratio_q       <= RATIO_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BIN_DIVISOR: bin_divisor_q <= cfg_data[7:0];
				CFG_PROB_FLOOR:  prob_floor_q  <= cfg_data[15:0];
				CFG_RATIO:       ratio_q       <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// ---- histogram memories -------------------------------------------------
	always_ff @(posedge clk) begin
		if (ctl.clear_wr) begin
			obj_hist[clear_addr_q] <= '0;
			bg_hist[clear_addr_q]  <= '0;
		end else begin
			if (ctl.train_obj) obj_hist[idx_q] <= sat_inc(obj_rd_q);
			if (ctl.train_bg)  bg_hist[idx_q]  <= sat_inc(bg_rd_q);
		end
		if (ctl.lookup) begin
			obj_rd_q <= obj_hist[idx_q];
			bg_rd_q  <= bg_hist[idx_q];
		end
	end

	// ---- control-side registers ---------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_addr_q <= '0;
			obj_total_q  <= '0;
			bg_total_q   <= '0;
			hits_q       <= '0;
			out_valid    <= 1'b0;
		end else begin
			if (ctl.clear_wr) clear_addr_q <= clear_addr_q + 1'b1;
			if (ctl.train_obj) obj_total_q <= sat_inc(obj_total_q);
			if (ctl.train_bg)  bg_total_q  <= sat_inc(bg_total_q);
			if (hit) hits_q <= hits_inc;
			if (ctl.out_load) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

	assign sts.clear_last = (clear_addr_q == ADDR_W'(HIST_DEPTH - 1));
	assign sts.out_busy   = out_valid && !out_ready;

	always_ff @(posedge clk) begin
		if (ctl.capture) idx_q <= idx_d;
	end

	// ---- restoring dividers: count * 2^16 / total, one bit per step ----------
	assign obj_trial = ctl.div_first ? {1'b0, obj_rem_q} : {obj_rem_q, 1'b0};
	assign bg_trial  = ctl.div_first ? {1'b0, bg_rem_q}  : {bg_rem_q, 1'b0};
	assign obj_bit   = (obj_trial >= {1'b0, obj_total_q});
	assign bg_bit    = (bg_trial  >= {1'b0, bg_total_q});

	always_ff @(posedge clk) begin
		if (ctl.div_load) begin
			obj_rem_q <= obj_rd_q;
			bg_rem_q  <= bg_rd_q;
			obj_quo_q <= '0;
			bg_quo_q  <= '0;
		end else if (ctl.div_step) begin
			obj_rem_q <= obj_bit ? COUNT_WIDTH'(obj_trial - {1'b0, obj_total_q})
				: COUNT_WIDTH'(obj_trial);
			bg_rem_q  <= bg_bit ? COUNT_WIDTH'(bg_trial - {1'b0, bg_total_q})
				: COUNT_WIDTH'(bg_trial);
			obj_quo_q <= {obj_quo_q[PROB_W-2:0], obj_bit};
			bg_quo_q  <= {bg_quo_q[PROB_W-2:0], bg_bit};
		end
	end

	// ---- floor and cross product ---------------------------------------------
	always_comb begin
		obj_p = '0;
		bg_p  = '0;
		if (obj_total_q != '0)
			obj_p = (obj_quo_q > PROB_W'(65536)) ? PROB_W'(65536) : obj_quo_q;
		if (bg_total_q != '0)
			bg_p = (bg_quo_q > PROB_W'(65536)) ? PROB_W'(65536) : bg_quo_q;
		obj_pf = (obj_p <= PROB_W'(prob_floor_q)) ? PROB_W'(prob_floor_q) : obj_p;
		bg_pf  = (bg_p  <= PROB_W'(prob_floor_q)) ? PROB_W'(prob_floor_q) : bg_p;
	end

	always_ff @(posedge clk) begin
		if (ctl.mul) begin
			obj_pf_q <= obj_pf;
			prod_q   <= PROD_W'(bg_pf) * PROD_W'(ratio_q);
		end
	end

	assign pass     = (PROD_W'({obj_pf_q, 8'b0}) >= prod_q);
	assign hit      = ctl.judge && pass;
	assign hits_inc = (hits_q == '1) ? hits_q : hits_q + 1'b1;

	// ---- output register ------------------------------------------------------
	assign idx_wide = {{BIN_INDEX_W{1'b0}}, idx_q};

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			is_object <= hit;
			bin_index <= idx_wide[BIN_INDEX_W-1:0];
			hit_count <= hit ? hits_inc : hits_q;
		end
	end

endmodule

// ----- hw/rtl/color_histogram_pixel_classifier.sv -----
// ----------------------------------------------------------------------------
// Colour histogram pixel classifier
// Trains object and background colour histograms and classifies pixels by
// a floored likelihood-ratio test.
// ----------------------------------------------------------------------------
//
//   channel   direction   beat contents
//   -------   ---------   ---------------------------------------------
//   pixel     in          cmd, blue, green, red
//   result    out         is_object, bin_index, hit_count
//   cfg_*     in          write enable, register index, 16-bit data
//
// A training beat or an unused command passes the lookup, read and done
// states to the result register; a classify beat also runs the 17-step
// restoring divider for both probabilities side by side, then multiplies.
// One pixel is in flight at a time; the next is taken once the result sits
// in the output register, which holds it until the sink takes the beat.
// After reset both histograms are cleared, one bin a cycle, with pixel.ready
// low; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
`include "color_histogram_pixel_classifier_defines.svh"

module color_histogram_pixel_classifier import chpc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	chpc_in_if.sink                pixel,
	chpc_out_if.source             result,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	chpc_ctl_t ctl;
	chpc_sts_t sts;

	// sequencer: owns the input handshake and the command of the item in flight
	chpc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pixel.valid),
		.in_ready (pixel.ready),
		.in_cmd   (pixel.cmd),
		.sts      (sts),
		.ctl      (ctl)
	);

	// datapath: quantiser, histograms, dividers, ratio test, output register
	chpc_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.sts       (sts),
		.blue      (pixel.blue),
		.green     (pixel.green),
		.red       (pixel.red),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_ready (result.ready),
		.out_valid (result.valid),
		.is_object (result.is_object),
		.bin_index (result.bin_index),
		.hit_count (result.hit_count)
	);

	// one pixel at a time: drop ready straight after a beat is taken
	`CHPC_ASSERT_NEXT(a_one_in_flight, clk, arst_n, pixel.valid && pixel.ready, !pixel.ready, "pixel accepted while another is in flight")

	// never overwrite a result beat the sink has not taken
	`CHPC_ASSERT_NOW(a_no_overwrite, clk, arst_n, ctl.out_load, !sts.out_busy, "result register overwritten before it was taken")

	// hold the input off while the clearing sweep runs
	`CHPC_ASSERT_NOW(a_clear_blocks_input, clk, arst_n, ctl.clear_wr, !pixel.ready, "pixel ready during histogram clear")

endmodule
